/* rtl/assert_macros.svh */
// assertion macros used by the parser top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/stip_pkg.sv */
// types and constants of the string to integer parser
`default_nettype none

package stip_pkg;

    // parse phase codes
    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_HEXPFX = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    // magnitude limits of the two result ranges
    localparam logic [63:0] LIM64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM64_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] LIM32_POS = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] LIM32_NEG = 64'h0000_0000_8000_0000;

    localparam logic [5:0] RADIX_RESET = 6'd10;

    // register indexes on the config port
    localparam logic REG_RADIX  = 1'b0;
    localparam logic REG_NARROW = 1'b1;

    // parse state carried from one character to the next
    typedef struct packed {
        logic [2:0]  phase;
        logic [63:0] acc;
        logic        neg;
        logic [5:0]  act_radix;
        logic        ovf;
        logic        dig;
    } stip_state_t;

endpackage

`default_nettype wire

/* rtl/stip_step.sv */
// one character step of the parser: phase update and multiply-add of the magnitude
`default_nettype none

module stip_step (
    input  wire stip_pkg::stip_state_t cur,
    input  wire logic [7:0]            ch,
    input  wire logic [5:0]            radix,
    input  wire logic                  narrow,
    output stip_pkg::stip_state_t      st_out,
    output logic                       mark_end
);

    // value of a digit character, 63 for anything else
    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [5:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 6'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = 6'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            v = 6'(c - 8'h41 + 8'd10);
        end else begin
            v = 6'd63;
        end
        return v;
    endfunction

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    logic [5:0]  d;
    logic [5:0]  start_radix;
    logic [5:0]  eff_radix;
    logic        use_start;
    logic        zero_start;
    logic        blank;
    logic        radix_ok;
    logic [63:0] limit;
    logic [69:0] prod;
    logic [70:0] sum;
    logic        over;

    assign d           = digit_value(ch);
    assign start_radix = (radix == 6'd0) ? 6'd10 : radix;
    assign use_start   = (cur.phase == stip_pkg::PH_SPACE) || (cur.phase == stip_pkg::PH_SIGNED);
    assign eff_radix   = use_start ? start_radix : cur.act_radix;
    assign zero_start  = (ch == CH_ZERO) && ((radix == 6'd0) || (radix == 6'd16));
    assign blank       = (ch == CH_SPACE) || (ch >= 8'd9 && ch <= 8'd13);
    assign radix_ok    = (eff_radix >= 6'd2) && (eff_radix <= 6'd36) && (d < eff_radix);

    always_comb begin
        if (narrow) begin
            limit = cur.neg ? stip_pkg::LIM32_NEG : stip_pkg::LIM32_POS;
        end else begin
            limit = cur.neg ? stip_pkg::LIM64_NEG : stip_pkg::LIM64_POS;
        end
    end

    // acc*r + d > limit is the same test as acc > (limit - d) / r
    assign prod = 70'(cur.acc) * 70'(eff_radix);
    assign sum  = 71'(prod) + 71'(d);
    assign over = cur.ovf || (cur.acc > limit) || (sum > 71'(limit));

    always_comb begin
        logic take;
        take     = 1'b0;
        st_out   = cur;
        mark_end = 1'b0;
        unique case (cur.phase)
            stip_pkg::PH_SPACE, stip_pkg::PH_SIGNED: begin
                if (cur.phase == stip_pkg::PH_SPACE && blank) begin
                    st_out = cur;
                end else if (cur.phase == stip_pkg::PH_SPACE && ch == CH_MINUS) begin
                    st_out.neg   = 1'b1;
                    st_out.phase = stip_pkg::PH_SIGNED;
                end else if (cur.phase == stip_pkg::PH_SPACE && ch == CH_PLUS) begin
                    st_out.phase = stip_pkg::PH_SIGNED;
                end else if (zero_start) begin
                    st_out.act_radix = (radix == 6'd0) ? 6'd8 : 6'd16;
                    st_out.dig       = 1'b1;
                    st_out.acc       = '0;
                    st_out.phase     = stip_pkg::PH_ZERO;
                    mark_end         = 1'b1;
                end else begin
                    st_out.act_radix = start_radix;
                    take             = 1'b1;
                end
            end
            stip_pkg::PH_ZERO: begin
                if (ch == CH_LOW_X || ch == CH_UP_X) begin
                    st_out.act_radix = 6'd16;
                    st_out.phase     = stip_pkg::PH_HEXPFX;
                end else begin
                    take = 1'b1;
                end
            end
            stip_pkg::PH_HEXPFX, stip_pkg::PH_DIGITS: begin
                take = 1'b1;
            end
            default: begin
                st_out.phase = stip_pkg::PH_DONE;
            end
        endcase

        if (take) begin
            if (!radix_ok) begin
                st_out.phase = stip_pkg::PH_DONE;
            end else begin
                st_out.acc   = over ? limit : sum[63:0];
                st_out.ovf   = over;
                st_out.dig   = 1'b1;
                st_out.phase = stip_pkg::PH_DIGITS;
                mark_end     = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/string_to_integer_parser.sv */
// top level of the string to integer parser with its stream and config ports
//
// usage:
// - characters arrive one per beat on the s_ channel, the byte in s_tdata, and s_tlast
//   marks the last character of a string; every string gives exactly one result beat
// - the m_ channel carries that result: value and consumed count in m_tdata,
//   overflow and digit flags in m_tuser
// - the apb port sets the radix (0 detects it from the prefix) and the 32-bit saturation
//   mode; write it only while no string is in flight
// - a character sits in the input register and is parsed from there into the parse state
//   or, when it ends a string, into the result register
// - throughput: one character per clock unless a final character waits; the loop that sets
//   it is the 64x6 bit multiply-add of the accumulator with its limit compare
// - when the receiver stalls, characters that end no string still flow through; a final
//   character waits in the input register until the result register is free
// - reset clears the parse state and both channels, radix returns to 10 and the
//   64-bit range is selected
`default_nettype none
`include "assert_macros.svh"

module string_to_integer_parser #(
    parameter int unsigned MAX_CHARS = 65535
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input characters
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // ch_code
    input  wire logic        s_tlast,   // final_char
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // number [63:0], consumed [79:64]
    output logic [1:0]       m_tuser,   // overflowed [0], digits_seen [1]
    // config registers
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned IDX_W = $clog2(MAX_CHARS + 1);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_CHARS);

    // config registers
    logic [5:0] radix_reg;
    logic       narrow_reg;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_ch_reg;
    logic       in_fin_reg;

    // parse state
    stip_pkg::stip_state_t st_reg, st_next, st_step, st_after;
    logic [IDX_W-1:0]      char_idx_reg, char_idx_next;
    logic [IDX_W-1:0]      end_idx_reg, end_idx_next, end_after;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [79:0] m_data_reg;
    logic [1:0]  m_user_reg;

    logic        consume;
    logic        at_limit;
    logic        mark_end;
    logic [31:0] end_wide;
    logic [63:0] number;

    // apb: no wait states, registers decoded on the word address bit
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg  <= stip_pkg::RADIX_RESET;
            narrow_reg <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                stip_pkg::REG_RADIX:  radix_reg  <= pwdata[5:0];
                stip_pkg::REG_NARROW: narrow_reg <= pwdata[0];
                default:              radix_reg  <= radix_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            stip_pkg::REG_RADIX:  prdata = {26'd0, radix_reg};
            stip_pkg::REG_NARROW: prdata = {31'd0, narrow_reg};
            default:              prdata = '0;
        endcase
    end

    // a character leaves the input register unless it ends a string and the result is blocked
    assign consume  = in_valid_reg && (!in_fin_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ch_reg  <= s_tdata;
            in_fin_reg <= s_tlast;
        end
    end

    stip_step u_step (
        .cur      (st_reg),
        .ch       (in_ch_reg),
        .radix    (radix_reg),
        .narrow   (narrow_reg),
        .st_out   (st_step),
        .mark_end (mark_end)
    );

    // characters past the length limit end the number like a non-digit
    assign at_limit = (char_idx_reg >= MAX_IDX);

    always_comb begin
        st_after = st_step;
        if (at_limit) begin
            st_after       = st_reg;
            st_after.phase = stip_pkg::PH_DONE;
        end
        end_after = (!at_limit && mark_end) ? char_idx_reg + 1'b1 : end_idx_reg;
    end

    always_comb begin
        st_next       = st_reg;
        char_idx_next = char_idx_reg;
        end_idx_next  = end_idx_reg;
        if (consume) begin
            if (in_fin_reg) begin
                // string done: back to the start state
                st_next           = '0;
                st_next.phase     = stip_pkg::PH_SPACE;
                char_idx_next     = '0;
                end_idx_next      = '0;
            end else begin
                st_next       = st_after;
                end_idx_next  = end_after;
                char_idx_next = at_limit ? char_idx_reg : char_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= '0;
            st_reg.phase  <= stip_pkg::PH_SPACE;
            char_idx_reg  <= '0;
            end_idx_reg   <= '0;
        end else begin
            st_reg        <= st_next;
            char_idx_reg  <= char_idx_next;
            end_idx_reg   <= end_idx_next;
        end
    end

    // result fields from the state after the final character
    assign end_wide = 32'(end_after);
    assign number   = st_after.neg ? (64'd0 - st_after.acc) : st_after.acc;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (consume && in_fin_reg) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && in_fin_reg) begin
            if (st_after.dig) begin
                m_data_reg <= {end_wide[15:0], number};
                m_user_reg <= {1'b1, st_after.ovf};
            end else begin
                m_data_reg <= '0;
                m_user_reg <= 2'b00;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // a string without digits reports zero value and zero count
    `ASSERT_ALWAYS(a_nodigit_zero, !(m_tvalid && !m_tuser[1]) || (m_tdata == '0),
                   "no-digit result not zero")
    // overflow only comes with digits
    `ASSERT_ALWAYS(a_ovf_has_digit, !(m_tvalid && m_tuser[0]) || m_tuser[1],
                   "overflow without digits")
    // a final character never overwrites a result still waiting
    `ASSERT_ALWAYS(a_no_overwrite, !(consume && in_fin_reg && m_valid_reg && !m_tready),
                   "result overwritten")
    // the parse state is back at the start after a string ends
    `ASSERT_NEXT(a_state_clear, consume && in_fin_reg,
                 (st_reg.phase == stip_pkg::PH_SPACE) && (char_idx_reg == '0) && !st_reg.dig,
                 "state not cleared after string")

endmodule

`default_nettype wire
